// ----- rtl/mrtu_pkg.sv -----
// Shared types, constants, function-code table and CRC function for the Modbus RTU request framer.
`default_nettype none
package mrtu_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [3:0] CMD_PAYLOAD = 4'd8;
	localparam logic [3:0] CMD_LAST_REQ = 4'd7;

	localparam logic [7:0] FC_WRITE_COIL = 8'd5;
	localparam logic [7:0] FC_WRITE_COILS = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS = 8'd16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0] COIL_ON_BYTE = 8'hFF;

	typedef enum logic {
		DK_FRAME = 1'b0,
		DK_ERROR = 1'b1
	} desc_kind_t;

	// one queued unit of work for the byte emitter
	typedef struct packed {
		desc_kind_t      kind;
		logic [2:0]      nbytes;
		logic            crc_end;
		logic [6:0][7:0] bytes;
	} desc_t;

	function automatic logic [7:0] func_code(input logic [2:0] sel);
		logic [7:0] fc;
		case (sel)
			3'd0: fc = 8'd1;
			3'd1: fc = 8'd2;
			3'd2: fc = 8'd3;
			3'd3: fc = 8'd4;
			3'd4: fc = 8'd5;
			3'd5: fc = 8'd6;
			3'd6: fc = 8'd15;
			default: fc = 8'd16;
		endcase
		return fc;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/mrtu_front.sv -----
// Front end: accepts request and payload words, tracks pending payload, builds descriptors.
`default_nettype none
module mrtu_front
	import mrtu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [3:0]  cmd,
	input  wire logic [7:0]  slave_addr,
	input  wire logic [15:0] reg_addr,
	input  wire logic [15:0] count_or_value,
	input  wire logic        coil_on,
	input  wire logic [7:0]  data_byte,
	output desc_t            desc
);

	logic [7:0] payload_left_q;
	logic [7:0] payload_left_d;
	logic [7:0] fc;
	logic [7:0] bc;

	always_comb begin
		fc = func_code(cmd[2:0]);
		if (fc == FC_WRITE_COILS) begin
			bc = count_or_value[10:3] + {7'd0, |count_or_value[2:0]};
		end else begin
			bc = {count_or_value[6:0], 1'b0};
		end

		desc = '0;
		desc.kind = DK_ERROR;
		payload_left_d = payload_left_q;
		if (cmd == CMD_PAYLOAD) begin
			if (payload_left_q != 8'd0) begin
				desc.kind = DK_FRAME;
				desc.nbytes = 3'd1;
				desc.bytes[0] = data_byte;
				desc.crc_end = (payload_left_q == 8'd1);
				payload_left_d = payload_left_q - 8'd1;
			end
		end else if (cmd <= CMD_LAST_REQ && payload_left_q == 8'd0) begin
			desc.kind = DK_FRAME;
			desc.bytes[0] = slave_addr;
			desc.bytes[1] = fc;
			desc.bytes[2] = reg_addr[15:8];
			desc.bytes[3] = reg_addr[7:0];
			if (fc == FC_WRITE_COIL) begin
				desc.bytes[4] = coil_on ? COIL_ON_BYTE : 8'h00;
				desc.bytes[5] = 8'h00;
			end else begin
				desc.bytes[4] = count_or_value[15:8];
				desc.bytes[5] = count_or_value[7:0];
			end
			if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
				desc.nbytes = 3'd7;
				desc.bytes[6] = bc;
				desc.crc_end = (bc == 8'd0);
				payload_left_d = bc;
			end else begin
				desc.nbytes = 3'd6;
				desc.crc_end = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_left_q <= 8'd0;
		end else if (accept) begin
			payload_left_q <= payload_left_d;
		end
	end

	a_req_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd != CMD_PAYLOAD && payload_left_q != 8'd0) |-> desc.kind == DK_ERROR)
		else $error("request accepted as frame while payload pending");

endmodule
`default_nettype wire

// ----- rtl/mrtu_queue.sv -----
// Short descriptor queue between front end and byte emitter.
`default_nettype none
module mrtu_queue
	import mrtu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	output logic       full,
	input  wire logic  pop,
	output logic       head_valid,
	output desc_t      head
);

	desc_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- rtl/mrtu_back.sv -----
// Byte emitter: walks queued descriptors, runs the CRC16 and drives the output register.
`default_nettype none
module mrtu_back
	import mrtu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire desc_t head,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [7:0] tx_byte,
	output logic       frame_end,
	output logic       seq_error
);

	logic        out_valid_q;
	logic [7:0]  tx_byte_q;
	logic        frame_end_q;
	logic        seq_error_q;
	logic [3:0]  pos_q;
	logic [15:0] crc_q;

	logic        adv;
	logic        last;
	logic [3:0]  n_ext;
	logic [7:0]  byte_d;
	logic        end_d;
	logic        err_d;
	logic [15:0] crc_d;

	always_comb begin
		n_ext = {1'b0, head.nbytes};
		adv = head_valid && (!out_valid_q || !out_stall);
		byte_d = 8'h00;
		end_d = 1'b0;
		err_d = 1'b0;
		crc_d = crc_q;
		if (head.kind == DK_ERROR) begin
			err_d = 1'b1;
			last = 1'b1;
		end else begin
			last = head.crc_end ? (pos_q == n_ext + 4'd1) : (pos_q == n_ext - 4'd1);
			if (pos_q < n_ext) begin
				byte_d = head.bytes[pos_q[2:0]];
				crc_d = crc_byte(crc_q, byte_d);
			end else if (pos_q == n_ext) begin
				byte_d = crc_q[7:0];
			end else begin
				byte_d = crc_q[15:8];
				end_d = 1'b1;
				crc_d = CRC_INIT;
			end
		end
		pop = adv && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q <= '0;
			crc_q <= CRC_INIT;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			pos_q <= last ? 4'd0 : pos_q + 4'd1;
			crc_q <= crc_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_byte_q <= byte_d;
			frame_end_q <= end_d;
			seq_error_q <= err_d;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte = tx_byte_q;
	assign frame_end = frame_end_q;
	assign seq_error = seq_error_q;

	a_end_not_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(frame_end_q && seq_error_q))
		else $error("frame end flagged on error word");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && seq_error_q) |-> tx_byte_q == 8'h00)
		else $error("error word carries non-zero byte");

endmodule
`default_nettype wire

// ----- rtl/modbus_rtu_request_framer.sv -----
// Top level of the Modbus RTU request framer.
// Input channel (in_valid / in_stall) takes one word per accept: cmd 0..7 starts a
// request with function 1,2,3,4,5,6,15,16; cmd 8 carries one payload byte of a
// multiple write; anything out of sequence gives a single error word.
// Output channel (out_valid / out_stall) gives one frame byte per word in transmit
// order; frame_end marks the CRC high byte, seq_error marks an error word.
// A front end classifies each input word and tracks pending payload; a two-entry
// descriptor queue feeds a byte emitter that runs the CRC16 one byte per cycle
// while out_stall does not hold it. The first byte of a request passes through the
// queue entry and then the emitter's output register. A read or single write gives
// six bytes and the two CRC bytes, a multiple-write header seven (and the CRC with a
// zero byte count), a payload byte one (and the CRC for the last), an error word one.
// New words are taken while earlier frames are still emitted, until the queue fills.
// Reset clears the queue, the pending payload count and the CRC to 0xFFFF.
// While out_stall is high a valid output word holds and the emitter waits; input words
// keep being accepted until the queue is full, then in_stall rises.
`default_nettype none
module modbus_rtu_request_framer
	import mrtu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  cmd,
	input  wire logic [7:0]  slave_addr,
	input  wire logic [15:0] reg_addr,
	input  wire logic [15:0] count_or_value,
	input  wire logic        coil_on,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       tx_byte,
	output logic             frame_end,
	output logic             seq_error
);

	logic  accept;
	logic  full;
	logic  pop;
	logic  head_valid;
	desc_t push_desc;
	desc_t head;

	assign in_stall = full;
	assign accept = in_valid && !full;

	mrtu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cmd            (cmd),
		.slave_addr     (slave_addr),
		.reg_addr       (reg_addr),
		.count_or_value (count_or_value),
		.coil_on        (coil_on),
		.data_byte      (data_byte),
		.desc           (push_desc)
	);

	mrtu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_desc  (push_desc),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mrtu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tx_byte    (tx_byte),
		.frame_end  (frame_end),
		.seq_error  (seq_error)
	);

endmodule
`default_nettype wire
